### sv/bba_pkg.sv
// ============================================================================
// Buddy block allocator package
// Shared constants, node encodings and transfer types for the allocator.
// ============================================================================
`default_nettype none

package bba_pkg;

  localparam int unsigned MemUnits   = 1024;
  localparam int unsigned OwnerCount = 256;
  localparam int unsigned LvlBits    = $clog2(MemUnits);
  localparam int unsigned IdxW       = LvlBits + 1;
  localparam int unsigned SizeW      = LvlBits + 1;
  localparam int unsigned DepW       = $clog2(LvlBits + 1);
  localparam int unsigned NodeCount  = 2 * MemUnits - 1;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusNoSpace = 2'd1;
  localparam logic [1:0] StatusNoOwner = 2'd2;

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [1:0] {
    NodeAbsent = 2'd0,
    NodeFree   = 2'd1,
    NodeSplit  = 2'd2,
    NodeAlloc  = 2'd3
  } node_st_e;

  typedef struct packed {
    node_st_e   st;
    logic [7:0] owner;
  } node_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    node_t data;
  } node_wr_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  owner_id;
    logic [10:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  block_start;
    logic [9:0]  block_end;
    logic [10:0] free_total;
  } rsp_t;

endpackage

`default_nettype wire

### sv/bba_node_mem.sv
// ============================================================================
// Buddy allocator node store
// Tree node memory with one write and one registered read port; the root
// node lives in a register so that reset leaves a single free block.
// ============================================================================
`default_nettype none

module bba_node_mem
  import bba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire node_wr_t wr_i,
  input  wire idx_t     rd_addr_i,
  output node_t         rd_data_o
);

  node_t mem_q [NodeCount];
  node_t rd_q;
  node_t root_q;
  logic  root_sel_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr != '0)) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q     <= '{st: NodeFree, owner: '0};
      root_sel_q <= 1'b0;
    end else begin
      if (wr_i.en && (wr_i.addr == '0)) begin
        root_q <= wr_i.data;
      end
      root_sel_q <= (rd_addr_i == '0);
    end
  end

  assign rd_data_o = root_sel_q ? root_q : rd_q;

endmodule

`default_nettype wire

### sv/buddy_block_allocator.sv
// ============================================================================
// Buddy block allocator
// Allocates and frees power-of-two blocks of a 1024-unit memory kept as a
// binary tree of nodes in a synchronous memory.
// ============================================================================
// Each node visited passes SRead and SEval, each climb step SClimb; an
// allocation splits via SSplit/SSplW as needed and takes the block in STake;
// a free passes SMRead, SMEval and SMWr per merge level, and SMRead, SMEval
// for a failed final merge check. A bad request answers in the cycle after
// it is accepted. One request at a time; the result is held for one cycle
// with valid_o; it cannot be stalled. Async reset leaves one free block.
`default_nettype none

module buddy_block_allocator
  import bba_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      valid_o,
  output rsp_t      rsp_o
);

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SRead  = 10'b0000000010,
    SEval  = 10'b0000000100,
    SSplit = 10'b0000001000,
    SSplW  = 10'b0000010000,
    STake  = 10'b0000100000,
    SClimb = 10'b0001000000,
    SMRead = 10'b0010000000,
    SMEval = 10'b0100000000,
    SMWr   = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [DepW-1:0]    dep_q, dep_d, tgt_q, tgt_d;
  logic [LvlBits-1:0] pos_q, pos_d;
  logic               op_q, op_d;
  logic [7:0]         owner_q, owner_d;
  logic [SizeW-1:0]   free_q, free_d;
  rsp_t               rsp_q, rsp_d;
  logic               valid_q, valid_d;

  node_wr_t           wr;
  idx_t               rd_addr;
  node_t              rd_data;
  idx_t               cur_idx;
  logic [SizeW-1:0]   blk_size;
  logic [LvlBits-1:0] blk_start;
  logic [LvlBits-1:0] blk_end;
  logic               req_bad;

  function automatic idx_t node_idx(input logic [DepW-1:0] dep,
                                    input logic [LvlBits-1:0] pos);
    node_idx = (idx_t'(1) << dep) - idx_t'(1) + idx_t'(pos);
  endfunction

  function automatic logic [DepW-1:0] tgt_depth(input logic [10:0] req);
    logic [DepW-1:0] lg;
    lg = '0;
    for (int j = LvlBits; j >= 0; j--) begin
      if (SizeW'(req) <= (SizeW'(1) << j)) begin
        lg = DepW'(j);
      end
    end
    tgt_depth = DepW'(LvlBits) - lg;
  endfunction

  bba_node_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign cur_idx   = node_idx(dep_q, pos_q);
  assign rd_addr   = (state_q == SMRead) ? node_idx(dep_q, pos_q ^ LvlBits'(1)) : cur_idx;
  assign blk_size  = SizeW'(MemUnits) >> dep_q;
  assign blk_start = pos_q << (DepW'(LvlBits) - dep_q);
  assign blk_end   = blk_start + LvlBits'(blk_size - SizeW'(1));
  assign req_bad   = (req_i.request_size == '0)
                  || (SizeW'(req_i.request_size) > SizeW'(MemUnits))
                  || (32'(req_i.owner_id) >= OwnerCount);

  always_comb begin
    state_d = state_q;
    dep_d   = dep_q;
    tgt_d   = tgt_q;
    pos_d   = pos_q;
    op_d    = op_q;
    owner_d = owner_q;
    free_d  = free_q;
    rsp_d   = rsp_q;
    valid_d = 1'b0;
    wr      = '0;
    case (state_q)
      SIdle: begin
        if (start) begin
          op_d    = req_i.op;
          owner_d = req_i.owner_id;
          dep_d   = '0;
          pos_d   = '0;
          tgt_d   = tgt_depth(req_i.request_size);
          if (req_i.op == OpAlloc && req_bad) begin
            valid_d = 1'b1;
            rsp_d   = '{status: StatusNoSpace, block_start: '0, block_end: '0,
                        free_total: free_q};
          end else if (req_i.op == OpFree && 32'(req_i.owner_id) >= OwnerCount) begin
            valid_d = 1'b1;
            rsp_d   = '{status: StatusNoOwner, block_start: '0, block_end: '0,
                        free_total: free_q};
          end else begin
            state_d = SRead;
          end
        end
      end
      SRead: begin
        state_d = SEval;
      end
      SEval: begin
        if (op_q == OpAlloc) begin
          if (rd_data.st == NodeFree) begin
            if (dep_q == tgt_q) begin
              state_d = STake;
            end else begin
              wr      = '{en: 1'b1, addr: cur_idx, data: '{st: NodeSplit, owner: '0}};
              state_d = SSplit;
            end
          end else if (rd_data.st == NodeSplit && dep_q < tgt_q) begin
            dep_d   = dep_q + DepW'(1);
            pos_d   = pos_q << 1;
            state_d = SRead;
          end else begin
            state_d = SClimb;
          end
        end else begin
          if (rd_data.st == NodeAlloc && rd_data.owner == owner_q) begin
            wr     = '{en: 1'b1, addr: cur_idx, data: '{st: NodeFree, owner: owner_q}};
            free_d = free_q + blk_size;
            rsp_d  = '{status: StatusDone, block_start: blk_start, block_end: blk_end,
                       free_total: free_d};
            if (dep_q == '0) begin
              valid_d = 1'b1;
              state_d = SIdle;
            end else begin
              state_d = SMRead;
            end
          end else if (rd_data.st == NodeSplit && dep_q < DepW'(LvlBits)) begin
            dep_d   = dep_q + DepW'(1);
            pos_d   = pos_q << 1;
            state_d = SRead;
          end else begin
            state_d = SClimb;
          end
        end
      end
      SSplit: begin
        wr      = '{en: 1'b1, addr: node_idx(dep_q + DepW'(1), (pos_q << 1) | LvlBits'(1)),
                    data: '{st: NodeFree, owner: '0}};
        dep_d   = dep_q + DepW'(1);
        pos_d   = pos_q << 1;
        state_d = (dep_d == tgt_q) ? STake : SSplW;
      end
      SSplW: begin
        wr      = '{en: 1'b1, addr: cur_idx, data: '{st: NodeSplit, owner: '0}};
        state_d = SSplit;
      end
      STake: begin
        wr      = '{en: 1'b1, addr: cur_idx, data: '{st: NodeAlloc, owner: owner_q}};
        free_d  = free_q - blk_size;
        valid_d = 1'b1;
        rsp_d   = '{status: StatusDone, block_start: blk_start, block_end: blk_end,
                    free_total: free_d};
        state_d = SIdle;
      end
      SClimb: begin
        if (dep_q == '0) begin
          valid_d = 1'b1;
          rsp_d   = '{status: (op_q == OpAlloc) ? StatusNoSpace : StatusNoOwner,
                      block_start: '0, block_end: '0, free_total: free_q};
          state_d = SIdle;
        end else if (pos_q[0]) begin
          pos_d = pos_q >> 1;
          dep_d = dep_q - DepW'(1);
        end else begin
          pos_d   = pos_q + LvlBits'(1);
          state_d = SRead;
        end
      end
      SMRead: begin
        state_d = SMEval;
      end
      SMEval: begin
        if (rd_data.st == NodeFree) begin
          dep_d   = dep_q - DepW'(1);
          pos_d   = pos_q >> 1;
          state_d = SMWr;
        end else begin
          valid_d = 1'b1;
          state_d = SIdle;
        end
      end
      SMWr: begin
        wr = '{en: 1'b1, addr: cur_idx, data: '{st: NodeFree, owner: owner_q}};
        if (dep_q == '0) begin
          valid_d = 1'b1;
          state_d = SIdle;
        end else begin
          state_d = SMRead;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      free_q  <= SizeW'(MemUnits);
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dep_q   <= dep_d;
    tgt_q   <= tgt_d;
    pos_q   <= pos_d;
    op_q    <= op_d;
    owner_q <= owner_d;
    rsp_q   <= rsp_d;
  end

  assign busy    = (state_q != SIdle);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status != StatusDone) |-> (rsp_o.block_start == '0 && rsp_o.block_end == '0))
    else $error("failed result carries a block range");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= SizeW'(MemUnits))
    else $error("free unit count exceeds memory size");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || valid_o))
    else $error("accepted transfer neither in progress nor answered");

  a_done_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == StatusDone) |-> (rsp_o.block_end >= rsp_o.block_start))
    else $error("block end precedes block start");

endmodule

`default_nettype wire
